FILE: hw/rtl/binomial_mod_prime_defines.svh
// ----------------------------------------------------------------------------
// binomial_mod_prime assertion macros
// Shared assertion forms for the binomial coefficient block.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_MOD_PRIME_DEFINES_SVH
`define BINOMIAL_MOD_PRIME_DEFINES_SVH

// same-cycle implication
`define BMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("binomial_mod_prime: same-cycle check failed");

// next-cycle implication
`define BMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("binomial_mod_prime: next-cycle check failed");

`endif

FILE: hw/rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Constants and types of the binomial coefficient block.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned VAL_W       = 30;
  localparam int unsigned ARG_W       = 10;

  localparam logic [VAL_W-1:0] PRIME    = 30'd1000000007;
  localparam logic [VAL_W-1:0] EXPONENT = 30'd1000000005;
  localparam logic [30:0]      BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

  localparam int unsigned MM_LAT   = 6;
  localparam int unsigned EXP_BITS = 30;
  localparam int unsigned POW_LAT  = EXP_BITS * MM_LAT;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } wr_t;

endpackage

FILE: hw/rtl/bmp_ram.sv
// ----------------------------------------------------------------------------
// bmp_ram
// Generic RAM, one write port, two registered read ports with read enable.
// ----------------------------------------------------------------------------
module bmp_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: hw/rtl/bmp_modmul.sv
// ----------------------------------------------------------------------------
// bmp_modmul
// Pipelined multiply mod prime with Barrett reduction, six stages.
// ----------------------------------------------------------------------------
module bmp_modmul (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [bmp_pkg::VAL_W-1:0] a_i,
  input  logic [bmp_pkg::VAL_W-1:0] b_i,
  output logic [bmp_pkg::VAL_W-1:0] y_o
);
  import bmp_pkg::*;

  logic [59:0] prod_q;
  logic [59:0] x2_q;
  logic [61:0] q2_q;
  logic [31:0] x3_q;
  logic [31:0] t3_q;
  logic [31:0] r4_q;
  logic [31:0] r5_q;
  logic [VAL_W-1:0] r6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 60'(a_i) * 60'(b_i);
      x2_q   <= prod_q;
      q2_q   <= 62'(prod_q[59:29]) * 62'(BARRETT_MU);
      x3_q   <= x2_q[31:0];
      t3_q   <= 32'(q2_q[61:31]) * 32'(PRIME);
      r4_q   <= x3_q - t3_q;
      r5_q   <= (r4_q >= 32'(PRIME)) ? r4_q - 32'(PRIME) : r4_q;
      r6_q   <= (r5_q >= 32'(PRIME)) ? VAL_W'(r5_q - 32'(PRIME)) : VAL_W'(r5_q);
    end
  end

  assign y_o = r6_q;

endmodule

FILE: hw/rtl/bmp_builder.sv
// ----------------------------------------------------------------------------
// bmp_builder
// Fill the factorial table after reset, waiting for each multiply result before the next entry.
// ----------------------------------------------------------------------------
module bmp_builder (
  input  logic         clk_i,
  input  logic         rst_ni,
  output bmp_pkg::wr_t wr_o,
  output logic         done_o
);
  import bmp_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_WAIT = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0]  cur_q, cur_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [VAL_W-1:0]  mm_y;

  bmp_modmul u_mm (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .a_i   (cur_q),
    .b_i   (VAL_W'(idx_q)),
    .y_o   (mm_y)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    wr_o    = '{we: 1'b0, addr: idx_q, data: mm_y};
    case (state_q)
      ST_INIT: begin
        wr_o    = '{we: 1'b1, addr: '0, data: VAL_W'(1)};
        cur_d   = VAL_W'(1);
        idx_d   = ADDR_W'(1);
        cnt_d   = '0;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (cnt_q == 3'(MM_LAT)) begin
          wr_o.we = 1'b1;
          cur_d   = mm_y;
          idx_d   = idx_q + ADDR_W'(1);
          cnt_d   = '0;
          if (idx_q == ADDR_W'(TABLE_DEPTH - 1)) begin
            state_d = ST_DONE;
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_DONE: begin
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign done_o = (state_q == ST_DONE);

endmodule

FILE: hw/rtl/bmp_powinv.sv
// ----------------------------------------------------------------------------
// bmp_powinv
// Pipelined Fermat inverse: square-and-multiply over the fixed exponent.
// ----------------------------------------------------------------------------
module bmp_powinv (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [bmp_pkg::VAL_W-1:0] base_i,
  output logic [bmp_pkg::VAL_W-1:0] inv_o
);
  import bmp_pkg::*;

  logic [VAL_W-1:0] acc [EXP_BITS+1];
  logic [VAL_W-1:0] sq  [EXP_BITS];

  assign acc[0] = VAL_W'(1);
  assign sq[0]  = base_i;

  for (genvar k = 0; k < EXP_BITS; k++) begin : g_step
    bmp_modmul u_acc (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (acc[k]),
      .b_i   (EXPONENT[k] ? sq[k] : VAL_W'(1)),
      .y_o   (acc[k+1])
    );
    if (k < EXP_BITS - 1) begin : g_sq
      bmp_modmul u_sq (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (sq[k]),
        .b_i   (sq[k]),
        .y_o   (sq[k+1])
      );
    end
  end

  assign inv_o = acc[EXP_BITS];

endmodule

FILE: hw/rtl/binomial_mod_prime.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime
// C(n,r) mod 1000000007 from a factorial table and a Fermat inverse.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  query    | in_valid_i, in_stall_o, n, r     | in
//  result   | out_valid_o, out_stall_i, coef   | out
//
// One item per cycle while in_stall_o is low; each item passes the table read,
// 32 chained six-stage modular multipliers and the output register.
// After reset the table fills, one entry per multiply result, with in_stall_o high.
// A stalled result freezes the whole pipeline; items enter again once the stall is released.
// ----------------------------------------------------------------------------
`include "binomial_mod_prime_defines.svh"

module binomial_mod_prime (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bmp_pkg::ARG_W-1:0] n_value_i,
  input  logic [bmp_pkg::ARG_W-1:0] r_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bmp_pkg::VAL_W-1:0] coefficient_o,
  output logic                      out_of_range_o
);
  import bmp_pkg::*;

  localparam int unsigned FN_LAT = MM_LAT + POW_LAT;
  localparam int unsigned LAT    = FN_LAT + MM_LAT;

  wr_t              wr;
  logic             built;
  logic             en;
  logic             accept;
  logic             oor_in;
  logic [VAL_W-1:0] fact_r, fact_nr, fact_n, fact_n_dup;
  logic [VAL_W-1:0] denom, inv, res;

  logic             vld_q [LAT+1];
  logic             oor_q [LAT+1];
  logic [VAL_W-1:0] fn_q  [1:FN_LAT];
  logic             out_valid_q;
  logic [VAL_W-1:0] coef_q;
  logic             oor_out_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !built || !en;
  assign accept     = in_valid_i && !in_stall_o;
  assign oor_in     = (r_value_i > n_value_i) || (32'(n_value_i) >= 32'(TABLE_DEPTH));

  bmp_builder u_builder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_o   (wr),
    .done_o (built)
  );

  bmp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_den (
    .clk_i     (clk_i),
    .we_i      (wr.we),
    .waddr_i   (wr.addr),
    .wdata_i   (wr.data),
    .re_i      (en),
    .raddr_a_i (ADDR_W'(r_value_i)),
    .raddr_b_i (ADDR_W'(n_value_i - r_value_i)),
    .rdata_a_o (fact_r),
    .rdata_b_o (fact_nr)
  );

  bmp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_num (
    .clk_i     (clk_i),
    .we_i      (wr.we),
    .waddr_i   (wr.addr),
    .wdata_i   (wr.data),
    .re_i      (en),
    .raddr_a_i (ADDR_W'(n_value_i)),
    .raddr_b_i (ADDR_W'(n_value_i)),
    .rdata_a_o (fact_n),
    .rdata_b_o (fact_n_dup)
  );

  bmp_modmul u_denom (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (fact_r),
    .b_i   (fact_nr),
    .y_o   (denom)
  );

  bmp_powinv u_inv (
    .clk_i  (clk_i),
    .en_i   (en),
    .base_i (denom),
    .inv_o  (inv)
  );

  bmp_modmul u_final (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (fn_q[FN_LAT]),
    .b_i   (inv),
    .y_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= accept;
      for (int i = 1; i <= LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oor_q[0] <= oor_in;
      for (int i = 1; i <= LAT; i++) begin
        oor_q[i] <= oor_q[i-1];
      end
      fn_q[1] <= fact_n;
      for (int i = 2; i <= FN_LAT; i++) begin
        fn_q[i] <= fn_q[i-1];
      end
      coef_q    <= oor_q[LAT] ? '0 : res;
      oor_out_q <= oor_q[LAT];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coefficient_o  = coef_q;
  assign out_of_range_o = oor_out_q;

  `BMP_ASSERT_IMPL(a_oor_zero, clk_i, rst_ni, out_valid_o && out_of_range_o, coefficient_o == '0)
  `BMP_ASSERT_IMPL(a_no_accept_unbuilt, clk_i, rst_ni, !built, in_stall_o)
  `BMP_ASSERT_IMPL(a_no_out_unbuilt, clk_i, rst_ni, !built, !out_valid_o)
  `BMP_ASSERT_NEXT(a_built_stays, clk_i, rst_ni, built, built)
  `BMP_ASSERT_IMPL(a_num_ports_agree, clk_i, rst_ni, vld_q[0], fact_n == fact_n_dup)

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives n/r queries into binomial_mod_prime with random idle and stall
// bursts and checks every result against a factorial-table predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned P = 64'd1000000007;
  localparam int unsigned DEPTH = bmp_pkg::TABLE_DEPTH;
  localparam int unsigned LIMIT = 2000000;

  typedef struct {
    logic [bmp_pkg::ARG_W-1:0] n;
    logic [bmp_pkg::ARG_W-1:0] r;
  } query_t;

  typedef struct {
    logic [bmp_pkg::VAL_W-1:0] coef;
    logic                      oor;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [bmp_pkg::ARG_W-1:0] n_value_i = '0;
  logic [bmp_pkg::ARG_W-1:0] r_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [bmp_pkg::VAL_W-1:0] coefficient_o;
  logic out_of_range_o;

  query_t  pending_q[$];
  answer_t expected_q[$];
  longint unsigned fact[DEPTH];
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  binomial_mod_prime dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b);
    return (a * b) % P;
  endfunction

  function automatic longint unsigned inverse(longint unsigned a);
    longint unsigned acc, sq, e;
    acc = 1;
    sq = a % P;
    e = P - 2;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, sq);
      sq = mulmod(sq, sq);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic answer_t binomial(query_t q);
    answer_t a;
    if (q.r > q.n || q.n >= DEPTH) begin
      a.coef = '0;
      a.oor = 1'b1;
    end else begin
      a.coef = bmp_pkg::VAL_W'(mulmod(fact[q.n], inverse(mulmod(fact[q.r], fact[q.n - q.r]))));
      a.oor = 1'b0;
    end
    return a;
  endfunction

  task automatic add(int n, int r);
    query_t q;
    q.n = bmp_pkg::ARG_W'(n);
    q.r = bmp_pkg::ARG_W'(r);
    pending_q = {pending_q, q};
  endtask

  always @(posedge clk_i) begin
    query_t q;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        q.n = n_value_i;
        q.r = r_value_i;
        expected_q = {expected_q, binomial(q)};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 12);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          q = pending_q.pop_front();
          n_value_i <= q.n;
          r_value_i <= q.r;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result coef=%0d oor=%0b", $time, coefficient_o,
                   out_of_range_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (coefficient_o !== e.coef) begin
            $display("%0t: coefficient expected %0d actual %0d", $time, e.coef, coefficient_o);
            errors++;
          end
          if (out_of_range_o !== e.oor) begin
            $display("%0t: out_of_range expected %0b actual %0b", $time, e.oor,
                     out_of_range_o);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int v;
    fact[0] = 1;
    for (int i = 1; i < DEPTH; i++) fact[i] = mulmod(fact[i - 1], longint'(unsigned'(i)));
    add(0, 0); add(1023, 0); add(1023, 1023); add(1023, 1); add(1023, 1022);
    add(1023, 511); add(1023, 512); add(5, 2); add(10, 10); add(1, 0);
    add(0, 1); add(0, 1023); add(1022, 1023); add(512, 513); add(341, 682);
    add(682, 341); add(2, 1); add(1000, 3);
    for (int i = 0; i < 500; i++) begin
      v = $urandom_range(0, 9);
      if (v < 6) begin
        add($urandom_range(0, 1023), 0);
        pending_q[$].r = bmp_pkg::ARG_W'($urandom_range(0, pending_q[$].n));
      end else if (v < 8) add($urandom_range(0, 1023), $urandom_range(0, 1023));
      else add($urandom_range(0, 1022), 0);
      if (v >= 8) begin
        pending_q[$].r = bmp_pkg::ARG_W'($urandom_range(pending_q[$].n + 1, 1023));
      end
      if (i == 400) calm = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() < 100);
    calm = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
